// ===== rtl/core/sbc_pkg.sv =====
package sbc_pkg;

	localparam int CACHE_ENTRIES = 8;
	localparam int COUNTER_WIDTH = 16;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	localparam logic [1:0] FUNC_GET = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam logic [2:0] K_GRANT = 3'd0;
	localparam logic [2:0] K_BUSY = 3'd1;
	localparam logic [2:0] K_OOB = 3'd2;
	localparam logic [2:0] K_WB = 3'd3;
	localparam logic [2:0] K_FETCH = 3'd4;
	localparam logic [2:0] K_ZERO = 3'd5;
	localparam logic [2:0] K_DONE = 3'd6;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] sector;
		logic [2:0]  access_mode;
		logic [2:0]  slot;
	} sbc_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  entry;
		logic [31:0] sector_out;
		logic        last;
	} sbc_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_HIT,
		ST_AGE,
		ST_VICTIM,
		ST_MISS_WB,
		ST_MISS_FILL,
		ST_MISS_GRANT,
		ST_FLUSH,
		ST_FLUSH_DONE,
		ST_SIMPLE,
		ST_EMIT
	} sbc_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_HIT_STEP,
		CMD_HIT_APPLY,
		CMD_AGE_STEP,
		CMD_MISS_WB,
		CMD_MISS_FILL,
		CMD_MISS_GRANT,
		CMD_FLUSH_STEP,
		CMD_FLUSH_DONE,
		CMD_SIMPLE
	} sbc_cmd_t;

	typedef struct packed {
		sbc_cmd_t cmd;
		logic     out_pop;
	} sbc_ctl_t;

	typedef struct packed {
		logic [1:0] func;
		logic       scan_end;
		logic       hit_found;
		logic       victim_found;
		logic       victim_dirty;
		logic       victim_oob;
		logic       zero_fill;
		logic       fill_oob;
		logic       flush_any;
		logic       out_valid;
	} sbc_stat_t;

endpackage

// ===== rtl/core/sector_buffer_cache_manager.sv =====
// Sector buffer cache descriptor manager with eight entries. One item is taken at a
// time. A get scans the entries one per cycle for a hit and again for aging on a miss;
// a flush scans one entry per cycle while the output register is free or being read, and
// can emit a result per entry. Results leave through a single output register and each
// waits for ready.
module sector_buffer_cache_manager (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbc_pkg::sbc_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sbc_pkg::sbc_out_t out_data
);
	import sbc_pkg::*;

	sbc_ctl_t  ctl;
	sbc_stat_t stat;

	sbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_ready(out_ready), .out_valid(out_valid), .stat(stat), .ctl(ctl)
	);

	sbc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_item(in_data), .ctl(ctl), .stat(stat), .out_item(out_data)
	);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result dropped");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_data.last)
		else $error("idle with partial results");
`endif
endmodule

// ===== rtl/core/sbc_datapath.sv =====
module sbc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  sbc_pkg::sbc_in_t  in_item,
	input  sbc_pkg::sbc_ctl_t ctl,
	output sbc_pkg::sbc_stat_t stat,
	output sbc_pkg::sbc_out_t out_item
);
	import sbc_pkg::*;

	logic [31:0]              total_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [31:0]              sec_q [CACHE_ENTRIES];
	logic [1:0]               mode_q [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] dirty_q;
	logic [COUNTER_WIDTH-1:0] hnd_q [CACHE_ENTRIES];
	logic [COUNTER_WIDTH-1:0] age_q [CACHE_ENTRIES];
	logic [COUNTER_WIDTH-1:0] per_q [CACHE_ENTRIES];

	sbc_in_t     req_q;
	logic [IDX_W:0] idx_q;
	logic        hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic        vic_q;
	logic [IDX_W-1:0] vic_idx_q;
	logic [$clog2(MAX_RESULTS+1)-1:0] nres_q;
	logic        out_valid_q;
	sbc_out_t    out_q;

	logic [IDX_W-1:0] ci;
	logic [COUNTER_WIDTH-1:0] age_new;
	logic better;
	logic [31:0] vsec;
	logic flush_take;
	logic flush_more;
	logic out_set;

	function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic oob(input logic [31:0] t, input logic [31:0] s);
		return (t != 32'd0) && (s >= t);
	endfunction

	assign ci = idx_q[IDX_W-1:0];
	assign age_new = sat_inc(age_q[ci]);
	assign better = !vic_q || (age_new > age_q[vic_idx_q]) ||
		((age_new == age_q[vic_idx_q]) && (per_q[ci] > per_q[vic_idx_q]));
	assign vsec = sec_q[vic_idx_q];
	assign flush_take = (hnd_q[ci] == '0) && dirty_q[ci] &&
		(nres_q < ($clog2(MAX_RESULTS+1))'(MAX_RESULTS));

	// another write-back follows in this flush, counting stale marks of this one
	always_comb begin
		flush_more = 1'b0;
		for (int j = 0; j < CACHE_ENTRIES; j++) begin
			if (j > int'(ci) && hnd_q[j] == '0 &&
				(dirty_q[j] || (sec_q[j] == sec_q[ci] && mode_q[j] == 2'd1)))
				flush_more = 1'b1;
		end
		if ((nres_q + 1'b1) >= ($clog2(MAX_RESULTS+1))'(MAX_RESULTS))
			flush_more = 1'b0;
	end

	always_comb begin
		case (ctl.cmd)
			CMD_HIT_APPLY, CMD_MISS_WB, CMD_MISS_FILL, CMD_MISS_GRANT,
			CMD_FLUSH_DONE, CMD_SIMPLE: out_set = 1'b1;
			CMD_AGE_STEP: out_set = stat.scan_end && !vic_q;
			CMD_FLUSH_STEP: out_set = flush_take;
			default: out_set = 1'b0;
		endcase
	end

	always_comb begin
		stat.func = req_q.func;
		stat.scan_end = (idx_q == (IDX_W+1)'(CACHE_ENTRIES));
		stat.hit_found = hit_q;
		stat.victim_found = vic_q;
		stat.victim_dirty = dirty_q[vic_idx_q];
		stat.victim_oob = oob(total_q, vsec);
		stat.zero_fill = req_q.access_mode[2];
		stat.fill_oob = oob(total_q, req_q.sector);
		stat.flush_any = (nres_q != '0);
		stat.out_valid = out_valid_q;
	end

	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			req_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			vic_q <= 1'b0;
			vic_idx_q <= '0;
			nres_q <= '0;
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				sec_q[i] <= '0;
				mode_q[i] <= '0;
				hnd_q[i] <= '0;
				age_q[i] <= '0;
				per_q[i] <= '0;
			end
		end else begin
			if (cfg_we) total_q <= cfg_wdata;
			if (out_set) out_valid_q <= 1'b1;
			else if (ctl.out_pop) out_valid_q <= 1'b0;
			case (ctl.cmd)
				CMD_LOAD: begin
					req_q <= in_item;
					idx_q <= '0;
					hit_q <= 1'b0;
					vic_q <= 1'b0;
					hit_idx_q <= '0;
					vic_idx_q <= '0;
					nres_q <= '0;
				end
				CMD_HIT_STEP: begin
					if (stat.scan_end) begin
						idx_q <= '0;
					end else begin
						if (!hit_q && valid_q[ci] && sec_q[ci] == req_q.sector) begin
							hit_q <= 1'b1;
							hit_idx_q <= ci;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				CMD_HIT_APPLY: begin
					out_q.entry <= hit_idx_q;
					out_q.sector_out <= req_q.sector;
					out_q.last <= 1'b1;
					idx_q <= '0;
					if (req_q.access_mode == 3'd1 && mode_q[hit_idx_q] == 2'd1) begin
						hnd_q[hit_idx_q] <= sat_inc(hnd_q[hit_idx_q]);
						per_q[hit_idx_q] <= sat_inc(per_q[hit_idx_q]);
						out_q.kind <= K_GRANT;
					end else if (hnd_q[hit_idx_q] == '0) begin
						mode_q[hit_idx_q] <= req_q.access_mode[1:0];
						if (req_q.access_mode[1]) dirty_q[hit_idx_q] <= 1'b1;
						hnd_q[hit_idx_q] <= COUNTER_WIDTH'(1);
						per_q[hit_idx_q] <= sat_inc(per_q[hit_idx_q]);
						out_q.kind <= K_GRANT;
					end else begin
						out_q.kind <= K_BUSY;
					end
				end
				CMD_AGE_STEP: begin
					if (stat.scan_end) begin
						if (!vic_q) begin
							out_q <= '{kind: K_BUSY, entry: '0,
								sector_out: req_q.sector, last: 1'b1};
						end
					end else begin
						if (hnd_q[ci] == '0) begin
							age_q[ci] <= age_new;
							if (better) begin
								vic_q <= 1'b1;
								vic_idx_q <= ci;
							end
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				CMD_MISS_WB: begin
					out_q.entry <= vic_idx_q;
					out_q.sector_out <= vsec;
					out_q.kind <= stat.victim_oob ? K_OOB : K_WB;
					out_q.last <= stat.victim_oob;
				end
				CMD_MISS_FILL: begin
					out_q.entry <= vic_idx_q;
					out_q.sector_out <= req_q.sector;
					if (req_q.access_mode[2]) begin
						out_q.kind <= K_ZERO;
						out_q.last <= 1'b0;
					end else begin
						out_q.kind <= stat.fill_oob ? K_OOB : K_FETCH;
						out_q.last <= stat.fill_oob;
					end
				end
				CMD_MISS_GRANT: begin
					out_q <= '{kind: K_GRANT, entry: vic_idx_q,
						sector_out: req_q.sector, last: 1'b1};
					mode_q[vic_idx_q] <= req_q.access_mode[1:0];
					per_q[vic_idx_q] <= COUNTER_WIDTH'(1);
					age_q[vic_idx_q] <= '0;
					hnd_q[vic_idx_q] <= COUNTER_WIDTH'(1);
					sec_q[vic_idx_q] <= req_q.sector;
					dirty_q[vic_idx_q] <= req_q.access_mode[1];
					valid_q[vic_idx_q] <= 1'b1;
				end
				CMD_FLUSH_STEP: begin
					if (flush_take) begin
						out_q.kind <= oob(total_q, sec_q[ci]) ? K_OOB : K_WB;
						out_q.entry <= ci;
						out_q.sector_out <= sec_q[ci];
						out_q.last <= !flush_more;
						for (int x = 0; x < CACHE_ENTRIES; x++) begin
							if (x != int'(ci) && sec_q[x] == sec_q[ci] && mode_q[x] == 2'd1)
								dirty_q[x] <= 1'b1;
						end
						mode_q[ci] <= 2'd1;
						dirty_q[ci] <= 1'b0;
						nres_q <= nres_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				CMD_FLUSH_DONE: begin
					out_q <= '{kind: K_DONE, entry: '0, sector_out: '0, last: 1'b1};
				end
				CMD_SIMPLE: begin
					out_q <= '{kind: K_DONE,
						entry: (req_q.func == FUNC_RELEASE) ? req_q.slot : 3'd0,
						sector_out: '0, last: 1'b1};
					if (req_q.func == FUNC_RELEASE) begin
						if ({1'b0, req_q.slot} < 4'(CACHE_ENTRIES) &&
							hnd_q[req_q.slot[IDX_W-1:0]] != '0)
							hnd_q[req_q.slot[IDX_W-1:0]] <=
								hnd_q[req_q.slot[IDX_W-1:0]] - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/core/sbc_ctrl.sv =====
module sbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	input  sbc_pkg::sbc_stat_t stat,
	output sbc_pkg::sbc_ctl_t  ctl
);
	import sbc_pkg::*;

	sbc_state_t state_q, state_d, ret_q, ret_d;
	logic last_pend;

	assign out_valid = stat.out_valid;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (stat.func)
					FUNC_GET: state_d = ST_HIT;
					FUNC_FLUSH: state_d = ST_FLUSH;
					default: state_d = ST_SIMPLE;
				endcase
			end
			ST_HIT: begin
				if (stat.scan_end)
					state_d = stat.hit_found ? ST_EMIT : ST_AGE;
				if (stat.scan_end && stat.hit_found) ret_d = ST_IDLE;
			end
			ST_AGE: begin
				if (stat.scan_end) begin
					if (!stat.victim_found) begin
						state_d = ST_EMIT;
						ret_d = ST_IDLE;
					end else if (stat.victim_dirty) begin
						state_d = ST_MISS_WB;
					end else begin
						state_d = ST_MISS_FILL;
					end
				end
			end
			ST_MISS_WB: begin
				state_d = ST_EMIT;
				ret_d = stat.victim_oob ? ST_IDLE : ST_MISS_FILL;
			end
			ST_MISS_FILL: begin
				state_d = ST_EMIT;
				ret_d = (!stat.zero_fill && stat.fill_oob) ? ST_IDLE : ST_MISS_GRANT;
			end
			ST_MISS_GRANT: begin
				state_d = ST_EMIT;
				ret_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (!stat.out_valid) begin
					if (stat.scan_end)
						state_d = stat.flush_any ? ST_IDLE : ST_FLUSH_DONE;
				end
			end
			ST_FLUSH_DONE: begin
				state_d = ST_EMIT;
				ret_d = ST_IDLE;
			end
			ST_SIMPLE: begin
				state_d = ST_EMIT;
				ret_d = ST_IDLE;
			end
			ST_EMIT: if (!stat.out_valid || out_ready) state_d = ret_q;
			default: state_d = ST_IDLE;
		endcase
	end

	assign last_pend = 1'b0;

	always_comb begin
		ctl.cmd = CMD_NONE;
		ctl.out_pop = out_valid && out_ready;
		case (state_q)
			ST_IDLE: if (in_valid) ctl.cmd = CMD_LOAD;
			ST_HIT: ctl.cmd = (stat.scan_end && stat.hit_found) ? CMD_HIT_APPLY
				: CMD_HIT_STEP;
			ST_AGE: ctl.cmd = CMD_AGE_STEP;
			ST_MISS_WB: ctl.cmd = CMD_MISS_WB;
			ST_MISS_FILL: ctl.cmd = CMD_MISS_FILL;
			ST_MISS_GRANT: ctl.cmd = CMD_MISS_GRANT;
			ST_FLUSH: if ((!stat.out_valid || out_ready) && !stat.scan_end)
				ctl.cmd = CMD_FLUSH_STEP;
			ST_FLUSH_DONE: ctl.cmd = CMD_FLUSH_DONE;
			ST_SIMPLE: ctl.cmd = CMD_SIMPLE;
			default: ctl.cmd = CMD_NONE;
		endcase
		if (last_pend) ctl.cmd = CMD_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
		end
	end
endmodule
